[src/cau_pkg.sv]
// Shared types and default constants for the complex arithmetic unit.
`default_nettype none

package cau_pkg;

  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int FIFO_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    logic is_sub;
    logic is_mul;
    logic is_div;
  } ctrl_t;

endpackage

`default_nettype wire

[src/cau_if.sv]
// Valid/ready channel interfaces for the operand and result words.
`default_nettype none

interface cau_in_if #(parameter int WORD_BITS = cau_pkg::WORD_BITS);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  op;
  logic signed [WORD_BITS-1:0] a_real;
  logic signed [WORD_BITS-1:0] a_imag;
  logic signed [WORD_BITS-1:0] b_real;
  logic signed [WORD_BITS-1:0] b_imag;

  modport source (output valid, op, a_real, a_imag, b_real, b_imag, input ready);
  modport sink (input valid, op, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if #(parameter int WORD_BITS = cau_pkg::WORD_BITS);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] res_real;
  logic signed [WORD_BITS-1:0] res_imag;
  logic                        div_zero;
  logic                        saturated;

  modport source (output valid, res_real, res_imag, div_zero, saturated, input ready);
  modport sink (input valid, res_real, res_imag, div_zero, saturated, output ready);
endinterface

`default_nettype wire

[src/complex_arithmetic_unit_core.sv]
// Top level of the complex arithmetic unit.
// Adds, subtracts, multiplies or divides two signed fixed-point complex numbers, one word
// per cycle unless the output is held off. Each word passes through the input queue and
// the divider, which resolves one quotient bit per pipeline stage for every operation so
// that all words leave in order. Quotients and right shifts truncate toward zero, each part
// saturates to the word range, and division by 0+0i returns zero with div_zero set.
`default_nettype none

module complex_arithmetic_unit_core #(
  parameter int WORD_BITS = cau_pkg::WORD_BITS,
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  cau_in_if.sink    in_ch,
  cau_out_if.source out_ch
);

  logic                        head_valid;
  logic                        pop;
  cau_pkg::ctrl_t              head_ctrl;
  logic signed [WORD_BITS-1:0] head_ar;
  logic signed [WORD_BITS-1:0] head_ai;
  logic signed [WORD_BITS-1:0] head_br;
  logic signed [WORD_BITS-1:0] head_bi;

  cau_front #(
    .W     (WORD_BITS),
    .DEPTH (cau_pkg::FIFO_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .pop        (pop),
    .head_valid (head_valid),
    .head_ctrl  (head_ctrl),
    .head_ar    (head_ar),
    .head_ai    (head_ai),
    .head_br    (head_br),
    .head_bi    (head_bi)
  );

  cau_back #(
    .W (WORD_BITS),
    .F (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_ctrl  (head_ctrl),
    .head_ar    (head_ar),
    .head_ai    (head_ai),
    .head_br    (head_br),
    .head_bi    (head_bi),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

[src/cau_front.sv]
// Front end: accepts operand words, decodes the opcode and queues them.
`default_nettype none

module cau_front #(
  parameter int W     = cau_pkg::WORD_BITS,
  parameter int DEPTH = cau_pkg::FIFO_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  cau_in_if.sink            in_ch,
  input  wire logic         pop,
  output logic              head_valid,
  output cau_pkg::ctrl_t    head_ctrl,
  output logic signed [W-1:0] head_ar,
  output logic signed [W-1:0] head_ai,
  output logic signed [W-1:0] head_br,
  output logic signed [W-1:0] head_bi
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cau_pkg::ctrl_t     ctrl_mem [DEPTH];
  logic signed [W-1:0] ar_mem [DEPTH];
  logic signed [W-1:0] ai_mem [DEPTH];
  logic signed [W-1:0] br_mem [DEPTH];
  logic signed [W-1:0] bi_mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  cau_pkg::ctrl_t   ctrl_in;

  assign in_ch.ready = (count_r != CNT_W'(DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign head_valid  = (count_r != '0);

  always_comb begin
    ctrl_in = '0;
    unique case (cau_pkg::op_t'(in_ch.op))
      cau_pkg::OP_ADD: ctrl_in = '0;
      cau_pkg::OP_SUB: ctrl_in.is_sub = 1'b1;
      cau_pkg::OP_MUL: ctrl_in.is_mul = 1'b1;
      cau_pkg::OP_DIV: ctrl_in.is_div = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctrl_mem[wr_ptr_r] <= ctrl_in;
      ar_mem[wr_ptr_r]   <= in_ch.a_real;
      ai_mem[wr_ptr_r]   <= in_ch.a_imag;
      br_mem[wr_ptr_r]   <= in_ch.b_real;
      bi_mem[wr_ptr_r]   <= in_ch.b_imag;
    end
  end

  assign head_ctrl = ctrl_mem[rd_ptr_r];
  assign head_ar   = ar_mem[rd_ptr_r];
  assign head_ai   = ai_mem[rd_ptr_r];
  assign head_br   = br_mem[rd_ptr_r];
  assign head_bi   = bi_mem[rd_ptr_r];

endmodule

`default_nettype wire

[src/cau_div_stage.sv]
// One restoring-division step for the real and imaginary quotients.
`default_nettype none

module cau_div_stage #(
  parameter int W   = cau_pkg::WORD_BITS,
  parameter int RW  = 3 * cau_pkg::WORD_BITS + cau_pkg::FRAC_BITS + 1,
  parameter int BIT = 0
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [RW-1:0] rem_re_i,
  input  wire logic [RW-1:0] rem_im_i,
  input  wire logic [2*W-1:0] den_i,
  input  wire logic [W-1:0]  q_re_i,
  input  wire logic [W-1:0]  q_im_i,
  output logic [RW-1:0]      rem_re_r,
  output logic [RW-1:0]      rem_im_r,
  output logic [2*W-1:0]     den_r,
  output logic [W-1:0]       q_re_r,
  output logic [W-1:0]       q_im_r
);

  logic [RW-1:0] dsh;
  logic          ge_re;
  logic          ge_im;

  assign dsh   = RW'(den_i) << BIT;
  assign ge_re = (rem_re_i >= dsh);
  assign ge_im = (rem_im_i >= dsh);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_re_r <= ge_re ? rem_re_i - dsh : rem_re_i;
      rem_im_r <= ge_im ? rem_im_i - dsh : rem_im_i;
      q_re_r   <= q_re_i | (ge_re ? (W'(1) << BIT) : '0);
      q_im_r   <= q_im_i | (ge_im ? (W'(1) << BIT) : '0);
      den_r    <= den_i;
    end
  end

endmodule

`default_nettype wire

[src/cau_back.sv]
// Back end: multiply, sum, scale, divide and saturate pipeline with output register.
`default_nettype none

module cau_back #(
  parameter int W = cau_pkg::WORD_BITS,
  parameter int F = cau_pkg::FRAC_BITS
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            head_valid,
  input  wire cau_pkg::ctrl_t  head_ctrl,
  input  wire logic signed [W-1:0] head_ar,
  input  wire logic signed [W-1:0] head_ai,
  input  wire logic signed [W-1:0] head_br,
  input  wire logic signed [W-1:0] head_bi,
  output logic                 pop,
  cau_out_if.source            out_ch
);

  localparam int PW   = 2 * W;
  localparam int SW   = 2 * W + 1;
  localparam int RW   = 3 * W + F + 1;
  localparam int NSTG = W;

  localparam logic [W-1:0] MAX_W = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [SW-1:0] MAX_SW = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] MIN_SW = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [SW-1:0] BIAS   = (SW'(1) << F) - SW'(1);
  localparam logic signed [SW-1:0] ZERO_SW = '0;

  logic en;

  // Stage 1: products and add/subtract.
  logic                 s1_valid_r;
  cau_pkg::ctrl_t       s1_ctrl_r;
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_bb_r, p_jj_r;
  logic [W-1:0]         s1_dre_r, s1_dim_r;
  logic                 s1_dsat_r;
  logic signed [W:0]    as_re, as_im;
  logic [W-1:0]         as_re_w, as_im_w;
  logic                 as_sat_re, as_sat_im;

  // Stage 2: sums of products.
  logic                 s2_valid_r;
  cau_pkg::ctrl_t       s2_ctrl_r;
  logic signed [SW-1:0] s2_mre_r, s2_mim_r, s2_nre_r, s2_nim_r;
  logic [PW-1:0]        s2_den_r;
  logic [W-1:0]         s2_dre_r, s2_dim_r;
  logic                 s2_dsat_r;

  // Stage 3 combinational.
  logic signed [SW-1:0] t_re, t_im, sh_re, sh_im;
  logic                 hi_re, lo_re, hi_im, lo_im;
  logic [W-1:0]         m_re_w, m_im_w;
  logic [SW-1:0]        mag_re, mag_im;
  logic [RW-1:0]        n_re, n_im, den_lim;

  // Divider chain and side pipeline, index 0 is the stage 3 register.
  logic [RW-1:0]  rem_re [NSTG+1];
  logic [RW-1:0]  rem_im [NSTG+1];
  logic [PW-1:0]  den    [NSTG+1];
  logic [W-1:0]   q_re   [NSTG+1];
  logic [W-1:0]   q_im   [NSTG+1];
  logic           sv_valid_r [NSTG+1];
  cau_pkg::ctrl_t sv_ctrl_r  [NSTG+1];
  logic [W-1:0]   sv_dre_r   [NSTG+1];
  logic [W-1:0]   sv_dim_r   [NSTG+1];
  logic           sv_dsat_r  [NSTG+1];
  logic           sv_neg_re_r [NSTG+1];
  logic           sv_neg_im_r [NSTG+1];
  logic           sv_ovf_re_r [NSTG+1];
  logic           sv_ovf_im_r [NSTG+1];
  logic           sv_dz_r    [NSTG+1];
  logic [RW-1:0]  s3_rem_re_r, s3_rem_im_r;
  logic [PW-1:0]  s3_den_r;

  // Output register.
  logic         out_valid_r;
  logic [W-1:0] res_re_r, res_im_r;
  logic         dz_r, sat_r;
  logic [W:0]   fx_re, fx_im;
  logic [W-1:0] fin_re, fin_im;
  logic         fin_dz, fin_sat;

  function automatic logic [W:0] fix_part(input logic [W-1:0] q, input logic neg,
                                          input logic ovf);
    logic over;
    begin
      if (neg) begin
        over = ovf || (q > MIN_W);
        fix_part = over ? {1'b1, MIN_W} : {1'b0, W'(-q)};
      end else begin
        over = ovf || q[W-1];
        fix_part = over ? {1'b1, MAX_W} : {1'b0, q};
      end
    end
  endfunction

  assign en  = !out_valid_r || out_ch.ready;
  assign pop = head_valid && en;

  assign as_re = head_ctrl.is_sub ? (W+1)'(head_ar) - (W+1)'(head_br)
                                  : (W+1)'(head_ar) + (W+1)'(head_br);
  assign as_im = head_ctrl.is_sub ? (W+1)'(head_ai) - (W+1)'(head_bi)
                                  : (W+1)'(head_ai) + (W+1)'(head_bi);
  assign as_sat_re = as_re[W] ^ as_re[W-1];
  assign as_sat_im = as_im[W] ^ as_im[W-1];
  assign as_re_w   = as_sat_re ? (as_re[W] ? MIN_W : MAX_W) : as_re[W-1:0];
  assign as_im_w   = as_sat_im ? (as_im[W] ? MIN_W : MAX_W) : as_im[W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ctrl_r <= head_ctrl;
      p_rr_r    <= PW'(head_ar) * PW'(head_br);
      p_ii_r    <= PW'(head_ai) * PW'(head_bi);
      p_ri_r    <= PW'(head_ar) * PW'(head_bi);
      p_ir_r    <= PW'(head_ai) * PW'(head_br);
      p_bb_r    <= PW'(head_br) * PW'(head_br);
      p_jj_r    <= PW'(head_bi) * PW'(head_bi);
      s1_dre_r  <= as_re_w;
      s1_dim_r  <= as_im_w;
      s1_dsat_r <= as_sat_re || as_sat_im;

      s2_ctrl_r <= s1_ctrl_r;
      s2_mre_r  <= SW'(p_rr_r) - SW'(p_ii_r);
      s2_mim_r  <= SW'(p_ri_r) + SW'(p_ir_r);
      s2_nre_r  <= SW'(p_rr_r) + SW'(p_ii_r);
      s2_nim_r  <= SW'(p_ir_r) - SW'(p_ri_r);
      s2_den_r  <= p_bb_r + p_jj_r;
      s2_dre_r  <= s1_dre_r;
      s2_dim_r  <= s1_dim_r;
      s2_dsat_r <= s1_dsat_r;
    end
  end

  always_comb begin
    t_re   = s2_mre_r + (s2_mre_r[SW-1] ? BIAS : ZERO_SW);
    t_im   = s2_mim_r + (s2_mim_r[SW-1] ? BIAS : ZERO_SW);
    sh_re  = t_re >>> F;
    sh_im  = t_im >>> F;
    hi_re  = sh_re > MAX_SW;
    lo_re  = sh_re < MIN_SW;
    hi_im  = sh_im > MAX_SW;
    lo_im  = sh_im < MIN_SW;
    m_re_w = hi_re ? MAX_W : (lo_re ? MIN_W : sh_re[W-1:0]);
    m_im_w = hi_im ? MAX_W : (lo_im ? MIN_W : sh_im[W-1:0]);
    mag_re = s2_nre_r[SW-1] ? SW'(-s2_nre_r) : SW'(s2_nre_r);
    mag_im = s2_nim_r[SW-1] ? SW'(-s2_nim_r) : SW'(s2_nim_r);
    n_re   = RW'(mag_re) << F;
    n_im   = RW'(mag_im) << F;
    den_lim = RW'(s2_den_r) << W;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sv_ctrl_r[0]   <= s2_ctrl_r;
      sv_dre_r[0]    <= s2_ctrl_r.is_mul ? m_re_w : s2_dre_r;
      sv_dim_r[0]    <= s2_ctrl_r.is_mul ? m_im_w : s2_dim_r;
      sv_dsat_r[0]   <= s2_ctrl_r.is_mul ? (hi_re || lo_re || hi_im || lo_im) : s2_dsat_r;
      sv_neg_re_r[0] <= s2_nre_r[SW-1];
      sv_neg_im_r[0] <= s2_nim_r[SW-1];
      sv_ovf_re_r[0] <= n_re >= den_lim;
      sv_ovf_im_r[0] <= n_im >= den_lim;
      sv_dz_r[0]     <= (s2_den_r == '0);
      s3_rem_re_r    <= n_re;
      s3_rem_im_r    <= n_im;
      s3_den_r       <= s2_den_r;
      for (int k = 1; k <= NSTG; k++) begin
        sv_ctrl_r[k]   <= sv_ctrl_r[k-1];
        sv_dre_r[k]    <= sv_dre_r[k-1];
        sv_dim_r[k]    <= sv_dim_r[k-1];
        sv_dsat_r[k]   <= sv_dsat_r[k-1];
        sv_neg_re_r[k] <= sv_neg_re_r[k-1];
        sv_neg_im_r[k] <= sv_neg_im_r[k-1];
        sv_ovf_re_r[k] <= sv_ovf_re_r[k-1];
        sv_ovf_im_r[k] <= sv_ovf_im_r[k-1];
        sv_dz_r[k]     <= sv_dz_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= NSTG; k++) begin
        sv_valid_r[k] <= 1'b0;
      end
    end else if (en) begin
      s1_valid_r    <= head_valid;
      s2_valid_r    <= s1_valid_r;
      sv_valid_r[0] <= s2_valid_r;
      for (int k = 1; k <= NSTG; k++) begin
        sv_valid_r[k] <= sv_valid_r[k-1];
      end
      out_valid_r <= sv_valid_r[NSTG];
    end
  end

  assign rem_re[0] = s3_rem_re_r;
  assign rem_im[0] = s3_rem_im_r;
  assign den[0]    = s3_den_r;
  assign q_re[0]   = '0;
  assign q_im[0]   = '0;

  for (genvar g = 0; g < NSTG; g++) begin : g_div
    cau_div_stage #(
      .W   (W),
      .RW  (RW),
      .BIT (W - 1 - g)
    ) u_stage (
      .clk      (clk),
      .en       (en),
      .rem_re_i (rem_re[g]),
      .rem_im_i (rem_im[g]),
      .den_i    (den[g]),
      .q_re_i   (q_re[g]),
      .q_im_i   (q_im[g]),
      .rem_re_r (rem_re[g+1]),
      .rem_im_r (rem_im[g+1]),
      .den_r    (den[g+1]),
      .q_re_r   (q_re[g+1]),
      .q_im_r   (q_im[g+1])
    );
  end

  always_comb begin
    fx_re = fix_part(q_re[NSTG], sv_neg_re_r[NSTG], sv_ovf_re_r[NSTG]);
    fx_im = fix_part(q_im[NSTG], sv_neg_im_r[NSTG], sv_ovf_im_r[NSTG]);
    if (!sv_ctrl_r[NSTG].is_div) begin
      fin_re  = sv_dre_r[NSTG];
      fin_im  = sv_dim_r[NSTG];
      fin_dz  = 1'b0;
      fin_sat = sv_dsat_r[NSTG];
    end else if (sv_dz_r[NSTG]) begin
      fin_re  = '0;
      fin_im  = '0;
      fin_dz  = 1'b1;
      fin_sat = 1'b0;
    end else begin
      fin_re  = fx_re[W-1:0];
      fin_im  = fx_im[W-1:0];
      fin_dz  = 1'b0;
      fin_sat = fx_re[W] || fx_im[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re_r <= fin_re;
      res_im_r <= fin_im;
      dz_r     <= fin_dz;
      sat_r    <= fin_sat;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.res_real  = res_re_r;
  assign out_ch.res_imag  = res_im_r;
  assign out_ch.div_zero  = dz_r;
  assign out_ch.saturated = sat_r;

endmodule

`default_nettype wire

[tb/tb_complex_arithmetic_unit_core.sv]
// Self-checking testbench for the complex arithmetic unit: random and directed words, exact model.
module tb_complex_arithmetic_unit_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    cau_pkg::op_t op;
    logic signed [31:0] ar, ai, br, bi;
  } operands_t;

  typedef struct {
    logic signed [31:0] re, im;
    logic dz, sat;
  } cplx_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  cau_in_if in_ch ();
  cau_out_if out_ch ();

  complex_arithmetic_unit_core dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  operands_t pending_q[$];
  cplx_result_t result_q[$];
  int errors = 0;
  int cycles = 0;
  int sent = 0;
  int total_items = 0;
  bit stim_done = 0;
  int tx_gap = 0;
  int rx_gap = 0;
  int hold_off = 0;

  function automatic logic signed [31:0] clip(input logic signed [127:0] v, inout logic sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic cplx_result_t compute_result(input operands_t w);
    logic signed [127:0] ar, ai, br, bi, re, im, den;
    cplx_result_t r;
    logic sat;
    ar = w.ar; ai = w.ai; br = w.br; bi = w.bi;
    sat = 1'b0;
    r.dz = 1'b0;
    case (w.op)
      cau_pkg::OP_ADD: begin re = ar + br; im = ai + bi; end
      cau_pkg::OP_SUB: begin re = ar - br; im = ai - bi; end
      cau_pkg::OP_MUL: begin
        re = ar * br - ai * bi;
        im = ar * bi + ai * br;
        re = (re < 0) ? -((-re) >>> cau_pkg::FRAC_BITS) : re >>> cau_pkg::FRAC_BITS;
        im = (im < 0) ? -((-im) >>> cau_pkg::FRAC_BITS) : im >>> cau_pkg::FRAC_BITS;
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          re = 0; im = 0; r.dz = 1'b1;
        end else begin
          re = ((ar * br + ai * bi) <<< cau_pkg::FRAC_BITS) / den;
          im = ((br * ai - ar * bi) <<< cau_pkg::FRAC_BITS) / den;
        end
      end
    endcase
    r.re = clip(re, sat);
    r.im = clip(im, sat);
    r.sat = sat;
    return r;
  endfunction

  function automatic logic signed [31:0] rand_part();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3: return $signed($urandom_range(0, 8)) - 4;
      4, 5: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_word(input cau_pkg::op_t op, input logic signed [31:0] ar, ai, br, bi);
    operands_t w;
    w.op = op; w.ar = ar; w.ai = ai; w.br = br; w.bi = bi;
    pending_q.push_back(w);
  endtask

  initial begin
    logic signed [31:0] mx, mn;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    for (int o = 0; o < 4; o++) begin
      add_word(cau_pkg::op_t'(o), mx, mx, mx, mx);
      add_word(cau_pkg::op_t'(o), mn, mn, mn, mn);
      add_word(cau_pkg::op_t'(o), mx, mn, mn, mx);
      add_word(cau_pkg::op_t'(o), 32'sh10000, -32'sh8000, 32'sh20000, 32'sh18000);
    end
    add_word(cau_pkg::OP_DIV, 32'sh10000, 32'sh10000, 0, 0);
    add_word(cau_pkg::OP_DIV, 0, 0, 0, 0);
    add_word(cau_pkg::OP_DIV, mx, mn, 1, 0);
    add_word(cau_pkg::OP_DIV, 0, 32'sh10000, 0, 32'sh10000);
    add_word(cau_pkg::OP_DIV, 32'sh10000, 0, 0, 32'sh20000);
    add_word(cau_pkg::OP_MUL, -1, -1, 1, 0);
    add_word(cau_pkg::OP_SUB, -1, 0, 0, -1);
    for (int i = 0; i < 950; i++)
      add_word(cau_pkg::op_t'($urandom_range(0, 3)), rand_part(), rand_part(), rand_part(),
               rand_part());
    total_items = pending_q.size();
    stim_done = 1;
  end

  // Sender: offers words from the pending queue with random bursts of gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.op <= '0;
      in_ch.a_real <= '0;
      in_ch.a_imag <= '0;
      in_ch.b_real <= '0;
      in_ch.b_imag <= '0;
    end else begin
      logic fire;
      fire = in_ch.valid && in_ch.ready;
      if (fire) begin
        result_q.push_back(compute_result(pending_q.pop_front()));
        sent <= sent + 1;
      end
      if (in_ch.valid && !fire) begin
      end else if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (stim_done && pending_q.size() > 0 &&
                   !(sent > 100 && sent < 800 && $urandom_range(0, 7) == 0)) begin
        in_ch.valid <= 1'b1;
        in_ch.op <= pending_q[0].op;
        in_ch.a_real <= pending_q[0].ar;
        in_ch.a_imag <= pending_q[0].ai;
        in_ch.b_real <= pending_q[0].br;
        in_ch.b_imag <= pending_q[0].bi;
      end else begin
        in_ch.valid <= 1'b0;
        if (sent > 100 && sent < 800) tx_gap <= $urandom_range(0, 3);
      end
    end
  end

  // Receiver: checks each word and stalls at random, once for a long stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          $error("unexpected word: res_real %0d res_imag %0d", out_ch.res_real, out_ch.res_imag);
          errors++;
        end else begin
          cplx_result_t e;
          e = result_q.pop_front();
          if (out_ch.res_real !== e.re) begin
            $error("res_real: expected %0d actual %0d", e.re, out_ch.res_real); errors++;
          end
          if (out_ch.res_imag !== e.im) begin
            $error("res_imag: expected %0d actual %0d", e.im, out_ch.res_imag); errors++;
          end
          if (out_ch.div_zero !== e.dz) begin
            $error("div_zero: expected %0d actual %0d", e.dz, out_ch.div_zero); errors++;
          end
          if (out_ch.saturated !== e.sat) begin
            $error("saturated: expected %0d actual %0d", e.sat, out_ch.saturated); errors++;
          end
        end
      end
      if (sent == 300 && hold_off == 0) begin
        hold_off <= 200;
        out_ch.ready <= 1'b0;
      end else if (hold_off > 1) begin
        hold_off <= hold_off - 1;
        out_ch.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (sent > 50 && sent < 800 && $urandom_range(0, 6) == 0) begin
        rx_gap <= $urandom_range(0, 3);
        out_ch.ready <= 1'b0;
      end else begin
        if (hold_off == 1) hold_off <= -1;
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done);
    while (sent < total_items || result_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && !out_ch.valid) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
